/* rtl/krq_pkg.sv */
// Package for the keyed record queue: constants, command and status codes.
package krq_pkg;
  localparam int CAPACITY_DEFAULT = 64;
  localparam int MAC_W = 48;
  localparam int STAMP_W = 32;
  localparam int REC_W = MAC_W + STAMP_W;
  localparam int OCC_W = 7;

  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;
  localparam logic [1:0] CMD_PEEK = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;
endpackage

/* rtl/krq_ram.sv */
// Generic single-port-write, single-read RAM with a registered read.
module krq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/keyed_record_queue.sv */
// Top level of the keyed record queue: command sequencer around one record RAM.
//
//  Channel   Ports                                   Direction
//  command   start, busy, command, mac_key, assoc_stamp  in (busy out)
//  result    done, status, out_mac, out_stamp, occupancy out
//
// A request is taken when start is high and busy is low. Enqueue and delete
// scan the stored records one per cycle through the RAM read port, and an
// enqueue shows its result once the scan has ended. A delete that hits then
// moves each later record one slot toward the head (a read, then a write).
// Dequeue reads slot 0 and then shifts as a delete of slot 0 does. The result
// shows for exactly one cycle with done high; the receiver cannot stall it.
// Reset clears only the count and the control state; the RAM holds no
// valid bits since a slot is read only after it has been written.
module keyed_record_queue #(
  parameter int CAPACITY = krq_pkg::CAPACITY_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command,
  input  logic [krq_pkg::MAC_W-1:0]   mac_key,
  input  logic [krq_pkg::STAMP_W-1:0] assoc_stamp,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [krq_pkg::MAC_W-1:0]   out_mac,
  output logic [krq_pkg::STAMP_W-1:0] out_stamp,
  output logic [krq_pkg::OCC_W-1:0]   occupancy
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CHECK = 6'b000100,
    S_SHIFT = 6'b001000,
    S_PEEK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  logic [1:0] cmd;
  logic [krq_pkg::REC_W-1:0] key;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;     // slot being requested from the RAM
  logic [CW-1:0] cmp_idx; // slot whose data is on rdata
  logic cmp_vld;
  logic [CW-1:0] pos;     // slot being written during the shift
  logic [1:0] st;
  logic [krq_pkg::REC_W-1:0] orec;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [krq_pkg::REC_W-1:0] wdata, rdata;

  krq_ram #(.WIDTH(krq_pkg::REC_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign status = st;
  assign out_mac = orec[krq_pkg::REC_W-1:krq_pkg::STAMP_W];
  assign out_stamp = orec[krq_pkg::STAMP_W-1:0];
  assign occupancy = krq_pkg::OCC_W'(count);

  logic match;
  assign match = cmp_vld && (rdata == key);

  // Read address: the scan index, or during the shift the slot after pos.
  always_comb begin
    raddr = AW'(idx);
    we = 1'b0;
    waddr = AW'(pos);
    wdata = rdata;
    if (state == S_IDLE && start && command == krq_pkg::CMD_ENQ) begin
      we = 1'b0;
    end
    if (state == S_SHIFT && cmp_vld) begin
      we = 1'b1;
    end
    if (state == S_CHECK && cmd == krq_pkg::CMD_ENQ && st == krq_pkg::ST_OK) begin
      we = 1'b1;
      waddr = AW'(count);
      wdata = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cmp_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          cmp_vld <= 1'b0;
          if (start) begin
            cmd <= command;
            key <= {mac_key, assoc_stamp};
            st <= krq_pkg::ST_OK;
            orec <= '0;
            idx <= '0;
            case (command)
              krq_pkg::CMD_ENQ: begin
                if (count >= CW'(CAPACITY)) begin
                  st <= krq_pkg::ST_FULL;
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              krq_pkg::CMD_DEL: state <= S_SCAN;
              krq_pkg::CMD_DEQ: begin
                if (count == '0) begin
                  st <= krq_pkg::ST_MISS;
                  state <= S_DONE;
                end else begin
                  // The head is read first, then removed by the shift.
                  pos <= '0;
                  state <= S_PEEK;
                end
              end
              default: begin
                if (count == '0) begin
                  st <= krq_pkg::ST_MISS;
                  state <= S_DONE;
                end else begin
                  idx <= count - CW'(1);
                  state <= S_PEEK;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // idx is requested this cycle; rdata holds slot cmp_idx.
          if (match) begin
            cmp_vld <= 1'b0;
            if (cmd == krq_pkg::CMD_ENQ) begin
              st <= krq_pkg::ST_DUP;
              state <= S_DONE;
            end else begin
              pos <= cmp_idx;
              idx <= cmp_idx + CW'(1);
              state <= S_SHIFT;
            end
          end else if (idx >= count) begin
            cmp_vld <= 1'b0;
            state <= S_CHECK;
          end else begin
            cmp_vld <= 1'b1;
            cmp_idx <= idx;
            idx <= idx + CW'(1);
          end
        end
        S_CHECK: begin
          // Last compared slot is on rdata now, if any was outstanding.
          if (match) begin
            if (cmd == krq_pkg::CMD_ENQ) begin
              st <= krq_pkg::ST_DUP;
              state <= S_DONE;
            end else begin
              pos <= cmp_idx;
              idx <= cmp_idx + CW'(1);
              state <= S_SHIFT;
            end
            cmp_vld <= 1'b0;
          end else if (cmp_vld) begin
            cmp_vld <= 1'b0;
          end else begin
            if (cmd == krq_pkg::CMD_ENQ) begin
              count <= count + CW'(1);
            end else begin
              st <= krq_pkg::ST_MISS;
            end
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          // Slot pos+1 arrives on rdata and is written into pos.
          if (cmp_vld) begin
            pos <= pos + CW'(1);
            cmp_vld <= 1'b0;
          end else if (idx < count) begin
            cmp_vld <= 1'b1;
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
          if (!cmp_vld && idx < count) begin
            idx <= idx + CW'(1);
          end
        end
        S_PEEK: begin
          if (!cmp_vld) begin
            cmp_vld <= 1'b1;
          end else begin
            orec <= rdata;
            cmp_vld <= 1'b0;
            if (cmd == krq_pkg::CMD_DEQ) begin
              idx <= CW'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
